FILE: rtl/core/ilp_pkg.sv
// shared types and constants for the interval lane packer
// no dependencies; every other file of the block uses this package
`default_nettype none

package ilp_pkg;

	// default sizes of the lane table and the cluster buffer
	localparam int MAX_LANES_DEF     = 16;
	localparam int CLUSTER_DEPTH_DEF = 32;

	// fixed field widths of the item channels
	localparam int MINUTE_W = 11;
	localparam int INDEX_W  = 10;
	localparam int LANE_W   = 4;
	localparam int COUNT_W  = 5;

	typedef logic [MINUTE_W-1:0] minute_t;
	typedef logic [INDEX_W-1:0]  index_t;
	typedef logic [LANE_W-1:0]   lane_field_t;
	typedef logic [COUNT_W-1:0]  count_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE_RD,
		ST_PRE_EMIT,
		ST_PLACE,
		ST_FIN_RD,
		ST_FIN_EMIT
	} ilp_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic place;
		logic emit;
		logic clear;
		logic final_flush;
	} ilp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic flush_req;
		logic last;
		logic out_free;
		logic at_end;
	} ilp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ilp_if.sv
// valid/ready channel interfaces for span items and result items
// depends on ilp_pkg for the field types
`default_nettype none

interface ilp_span_if;
	logic             valid;
	logic             ready;
	ilp_pkg::minute_t start_minute;
	ilp_pkg::minute_t end_minute;
	logic             list_end;

	modport source (output valid, output start_minute, output end_minute, output list_end,
		input ready);
	modport sink (input valid, input start_minute, input end_minute, input list_end,
		output ready);
endinterface

interface ilp_result_if;
	logic                 valid;
	logic                 ready;
	ilp_pkg::index_t      span_index;
	ilp_pkg::lane_field_t lane;
	ilp_pkg::count_t      lane_count;
	logic                 overflow;
	logic                 run_last;

	modport source (output valid, output span_index, output lane, output lane_count,
		output overflow, output run_last, input ready);
	modport sink (input valid, input span_index, input lane, input lane_count,
		input overflow, input run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ilp_ctrl.sv
// controller state machine of the interval lane packer
// depends on ilp_pkg for the state, command and status types
`default_nettype none

module ilp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ilp_pkg::ilp_stat_t stat,
	output ilp_pkg::ilp_cmd_t       cmd
);

	ilp_pkg::ilp_state_t state_q;
	ilp_pkg::ilp_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ilp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = stat.flush_req ? ilp_pkg::ST_PRE_RD : ilp_pkg::ST_PLACE;
				end
			end
			ilp_pkg::ST_PRE_RD: begin
				state_nxt = ilp_pkg::ST_PRE_EMIT;
			end
			ilp_pkg::ST_PRE_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.at_end) begin
						cmd.clear = 1'b1;
						state_nxt = ilp_pkg::ST_PLACE;
					end
				end
			end
			ilp_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
				state_nxt = stat.last ? ilp_pkg::ST_FIN_RD : ilp_pkg::ST_IDLE;
			end
			ilp_pkg::ST_FIN_RD: begin
				state_nxt = ilp_pkg::ST_FIN_EMIT;
			end
			ilp_pkg::ST_FIN_EMIT: begin
				cmd.final_flush = 1'b1;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.at_end) begin
						cmd.clear = 1'b1;
						state_nxt = ilp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ilp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/ilp_datapath.sv
// datapath: lane end table, first-fit search, cluster buffer and output register
// depends on ilp_pkg; driven by ilp_ctrl through command and status structs
`default_nettype none

module ilp_datapath #(
	parameter int MAX_LANES     = ilp_pkg::MAX_LANES_DEF,
	parameter int CLUSTER_DEPTH = ilp_pkg::CLUSTER_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ilp_pkg::minute_t     in_start,
	input  wire ilp_pkg::minute_t     in_end,
	input  wire logic                 in_last,
	input  wire ilp_pkg::ilp_cmd_t    cmd,
	output ilp_pkg::ilp_stat_t        stat,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output ilp_pkg::index_t           out_index,
	output ilp_pkg::lane_field_t      out_lane,
	output ilp_pkg::count_t           out_count,
	output logic                      out_overflow,
	output logic                      out_run_last
);

	localparam int LW = $clog2(MAX_LANES);
	localparam int CW = $clog2(MAX_LANES + 1);
	localparam int AW = $clog2(CLUSTER_DEPTH);
	localparam int FW = $clog2(CLUSTER_DEPTH + 1);

	// captured item
	ilp_pkg::minute_t start_q;
	ilp_pkg::minute_t end_q;
	logic             last_q;
	logic             forced_q;

	// cluster state
	ilp_pkg::minute_t lane_end_q [MAX_LANES];
	logic [CW-1:0]    lanes_q;
	ilp_pkg::minute_t latest_q;
	logic [FW-1:0]    fill_q;
	ilp_pkg::index_t  first_q;
	ilp_pkg::index_t  count_q;
	logic [AW-1:0]    ptr_q;

	// cluster buffer: overflow mark above the lane
	logic [LW:0]      buf_mem [CLUSTER_DEPTH];
	logic [LW:0]      rd_data_s1;
	logic [AW-1:0]    rd_addr;

	// output register
	logic                 out_valid_q;
	ilp_pkg::index_t      out_index_q;
	ilp_pkg::lane_field_t out_lane_q;
	ilp_pkg::count_t      out_count_q;
	logic                 out_overflow_q;
	logic                 out_run_last_q;

	// first-fit search
	logic             natural_close;
	logic             full;
	logic             hit_any;
	logic [LW-1:0]    hit_sel;
	logic             room;
	logic [LW-1:0]    lane_sel;
	logic             lane_ovf;

	// close decisions for an incoming item
	assign natural_close = (fill_q != '0) && (in_start >= latest_q);
	assign full          = fill_q >= FW'(CLUSTER_DEPTH);

	assign stat.flush_req = natural_close || full;
	assign stat.last      = last_q;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.at_end    = FW'(ptr_q) == (fill_q - FW'(1));

	// lowest lane in use whose end is at or before the start
	always_comb begin
		hit_any = 1'b0;
		hit_sel = '0;
		for (int l = MAX_LANES - 1; l >= 0; l--) begin
			if ((CW'(l) < lanes_q) && (lane_end_q[l] <= start_q)) begin
				hit_any = 1'b1;
				hit_sel = LW'(l);
			end
		end
	end

	assign room     = lanes_q < CW'(MAX_LANES);
	assign lane_sel = hit_any ? hit_sel : (room ? lanes_q[LW-1:0] : LW'(MAX_LANES - 1));
	assign lane_ovf = !hit_any && !room;

	// read the next entry ahead while an item goes out
	assign rd_addr = cmd.emit ? ptr_q + AW'(1) : ptr_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			start_q <= in_start;
			end_q   <= in_end;
		end
	end

	// control and cluster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			forced_q <= 1'b0;
			lanes_q  <= '0;
			latest_q <= '0;
			fill_q   <= '0;
			first_q  <= '0;
			count_q  <= '0;
			ptr_q    <= '0;
		end else begin
			if (cmd.accept) begin
				last_q   <= in_last;
				forced_q <= !natural_close && full;
				ptr_q    <= '0;
			end
			if (cmd.place) begin
				fill_q  <= fill_q + FW'(1);
				count_q <= count_q + ilp_pkg::index_t'(1);
				ptr_q   <= '0;
				if (!hit_any && room) begin
					lanes_q <= lanes_q + CW'(1);
				end
				if ((fill_q == '0) || (end_q > latest_q)) begin
					latest_q <= end_q;
				end
				if (fill_q == '0) begin
					first_q <= count_q;
				end
			end
			if (cmd.emit) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (cmd.clear) begin
				fill_q   <= '0;
				lanes_q  <= '0;
				latest_q <= '0;
				if (cmd.final_flush) begin
					count_q <= '0;
					first_q <= '0;
				end
			end
		end
	end

	// lane end table write
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			lane_end_q[lane_sel] <= end_q;
		end
	end

	// cluster buffer, registered read
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			buf_mem[fill_q[AW-1:0]] <= {lane_ovf, lane_sel};
		end
		rd_data_s1 <= buf_mem[rd_addr];
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index_q    <= first_q + ilp_pkg::index_t'(ptr_q);
			out_lane_q     <= ilp_pkg::lane_field_t'(rd_data_s1[LW-1:0]);
			out_count_q    <= ilp_pkg::count_t'(lanes_q);
			out_overflow_q <= rd_data_s1[LW] | (forced_q & !cmd.final_flush);
			out_run_last_q <= stat.at_end && (cmd.final_flush || !last_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_index    = out_index_q;
	assign out_lane     = out_lane_q;
	assign out_count    = out_count_q;
	assign out_overflow = out_overflow_q;
	assign out_run_last = out_run_last_q;

`ifndef SYNTH
	a_lanes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lanes_q <= CW'(MAX_LANES))
		else $error("lane count beyond lane table");

	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> fill_q < FW'(CLUSTER_DEPTH))
		else $error("span placed into a full cluster buffer");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwrites an item not yet taken");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> FW'(ptr_q) < fill_q)
		else $error("flush reads past the buffered cluster");

	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (cmd.emit && stat.at_end))
		else $error("cluster cleared before its last item went out");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/interval_lane_packer_unit.sv
// interval lane packer top level: ilp_ctrl plus ilp_datapath, depends on ilp_pkg and ilp_if
// an item that closes no cluster goes through accept, then first-fit placement
// a cluster close adds a buffer read, then sends out each buffered span in turn
// a list end adds the same again for its own cluster: results stream one per cycle while results.ready holds
// reset (arst_n low, asynchronous) clears the controller, counters and output valid
`default_nettype none

module interval_lane_packer_unit #(
	parameter int MAX_LANES     = ilp_pkg::MAX_LANES_DEF,
	parameter int CLUSTER_DEPTH = ilp_pkg::CLUSTER_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ilp_span_if.sink     spans,
	ilp_result_if.source results
);

	ilp_pkg::ilp_cmd_t  cmd;
	ilp_pkg::ilp_stat_t stat;

	// sequencing
	ilp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (spans.valid),
		.in_ready (spans.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// placement and cluster storage
	ilp_datapath #(
		.MAX_LANES     (MAX_LANES),
		.CLUSTER_DEPTH (CLUSTER_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_start     (spans.start_minute),
		.in_end       (spans.end_minute),
		.in_last      (spans.list_end),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (results.ready),
		.out_valid    (results.valid),
		.out_index    (results.span_index),
		.out_lane     (results.lane),
		.out_count    (results.lane_count),
		.out_overflow (results.overflow),
		.out_run_last (results.run_last)
	);

endmodule

`default_nettype wire
